>>> rtl/core/nthp_pkg.sv
`default_nettype none
package nthp_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  // The count holds the entry total itself and is at least as wide as its port.
  localparam int CNT_RAW_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W = (CNT_RAW_W > 5) ? CNT_RAW_W : 5;

  localparam int ADDR_W = 16;
  localparam int HOP_W = 8;
  localparam int EPOCH_W = 16;
  localparam int SIG_W = 8;
  localparam int LQI_W = 8;
  localparam int AVG_W = 16;
  localparam int WGT_W = 9;
  localparam int PHOP_W = 5;

  localparam logic [WGT_W-1:0] EWMA_UNITY = 9'h100;
  localparam logic [AVG_W-1:0] AVG_UNITY = 16'h0100;
  localparam logic [PHOP_W-1:0] NO_HOPS = 5'd17;
  localparam logic signed [SIG_W-1:0] MIN_SIG_RESET = -8'sd95;
  localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'h040;

  localparam logic [1:0] KIND_BEACON = 2'd0;
  localparam logic [1:0] KIND_RELAY = 2'd1;
  localparam logic [1:0] KIND_LOCAL = 2'd2;

  localparam logic REG_MIN_SIGNAL = 1'b0;
  localparam logic REG_EWMA_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_KNOWN = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_WEAK  = 2'd3
  } status_t;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic              free;
    logic [IDX_W-1:0]  free_slot;
    logic [HOP_W-1:0]  last_hop;
    logic [AVG_W-1:0]  gap_avg;
  } scan_tok_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              clr;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [HOP_W-1:0]  last_hop;
    logic [SIG_W-1:0]  signal;
    logic [LQI_W-1:0]  quality;
    logic [AVG_W-1:0]  gap_avg;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/nthp_cell.sv
`default_nettype none
module nthp_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [nthp_pkg::IDX_W-1:0] idx,
  input  nthp_pkg::cell_cmd_t      cmd,
  input  nthp_pkg::scan_tok_t      tok_in,
  output nthp_pkg::scan_tok_t      tok_out
);
  import nthp_pkg::*;

  logic              valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [HOP_W-1:0]  last_hop_r;
  logic [SIG_W-1:0]  signal_r;
  logic [LQI_W-1:0]  quality_r;
  logic [AVG_W-1:0]  gap_avg_r;
  scan_tok_t         tok_r;
  scan_tok_t         tok_nxt;
  logic              sel;

  assign sel = cmd.wr && (cmd.idx == idx);

  // The first valid match upstream wins; the first free slot upstream wins.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld) begin
      if (valid_r) begin
        if (!tok_in.found && (addr_r == tok_in.addr)) begin
          tok_nxt.found    = 1'b1;
          tok_nxt.slot     = idx;
          tok_nxt.last_hop = last_hop_r;
          tok_nxt.gap_avg  = gap_avg_r;
        end
      end else if (!tok_in.free) begin
        tok_nxt.free      = 1'b1;
        tok_nxt.free_slot = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (cmd.clr) begin
        valid_r <= 1'b0;
      end else if (sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      addr_r     <= cmd.addr;
      last_hop_r <= cmd.last_hop;
      signal_r   <= cmd.signal;
      quality_r  <= cmd.quality;
      gap_avg_r  <= cmd.gap_avg;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

>>> rtl/core/nthp_ctrl.sv
`default_nettype none
module nthp_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [nthp_pkg::ADDR_W-1:0]     in_sender_addr,
  input  logic [nthp_pkg::HOP_W-1:0]      in_hop_count,
  input  logic [nthp_pkg::EPOCH_W-1:0]    in_restart_epoch,
  input  logic signed [nthp_pkg::SIG_W-1:0] in_signal_strength,
  input  logic [nthp_pkg::LQI_W-1:0]      in_link_quality,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_parent_valid,
  output logic [nthp_pkg::ADDR_W-1:0]     out_parent_addr,
  output logic [nthp_pkg::PHOP_W-1:0]     out_parent_hops,
  output logic [4:0]                      out_neighbor_count,
  output logic [nthp_pkg::AVG_W-1:0]      out_average_gap,
  output logic                            out_announce,
  output logic [nthp_pkg::PHOP_W-1:0]     out_announce_hops,
  output logic                            out_forward,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [nthp_pkg::WGT_W-1:0]      cfg_wdata,
  output nthp_pkg::scan_tok_t             head_tok,
  input  nthp_pkg::scan_tok_t             tail_tok,
  output nthp_pkg::cell_cmd_t             cmd
);
  import nthp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_SCAN = 6'b000100,
    S_MULT = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic signed [SIG_W-1:0] min_sig_r;
  logic [WGT_W-1:0]        weight_r;

  // Table-wide state.
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [PHOP_W-1:0]  best_hops_r, best_hops_nxt;
  logic [ADDR_W-1:0]  parent_addr_r, parent_addr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Transaction held while it is worked on.
  logic [1:0]              req_kind_r;
  logic [ADDR_W-1:0]       req_addr_r;
  logic [HOP_W-1:0]        req_hop_r;
  logic [EPOCH_W-1:0]      req_epoch_r;
  logic signed [SIG_W-1:0] req_sig_r;
  logic [LQI_W-1:0]        req_lqi_r;

  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [HOP_W-1:0]  base_hop_r, base_hop_nxt;
  logic [AVG_W-1:0]  base_avg_r, base_avg_nxt;
  logic [16:0]       prod_gap_r;
  logic [24:0]       prod_avg_r;
  logic [AVG_W-1:0]  avg_out_r, avg_out_nxt;
  scan_tok_t         head_tok_r, head_tok_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_status_r;
  logic              o_pvalid_r;
  logic [ADDR_W-1:0] o_paddr_r;
  logic [PHOP_W-1:0] o_phops_r;
  logic [4:0]        o_count_r;
  logic [AVG_W-1:0]  o_avg_r;
  logic              o_ann_r;
  logic [PHOP_W-1:0] o_ann_hops_r;
  logic              o_fwd_r;

  logic              accept;
  logic              is_beacon;
  logic              new_epoch;
  logic              load_out;
  logic              upd_entry;
  logic [WGT_W-1:0]  w_eff;
  logic [WGT_W-1:0]  w_inv;
  logic [HOP_W-1:0]  gap;
  logic [17:0]       sum;
  logic              fwd;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign is_beacon = (req_kind_r == KIND_BEACON);
  assign new_epoch = (req_epoch_r != epoch_r);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign upd_entry = (status_r == ST_KNOWN) || (status_r == ST_NEW);

  assign w_eff = (weight_r > EWMA_UNITY) ? EWMA_UNITY : weight_r;
  assign w_inv = EWMA_UNITY - w_eff;
  assign gap   = req_hop_r - base_hop_r;
  assign sum   = 18'(prod_gap_r) + 18'(prod_avg_r[24:8]);

  always_comb begin
    case (req_kind_r)
      KIND_RELAY: fwd = (count_r > CNT_W'(1)) && best_valid_r;
      KIND_LOCAL: fwd = (count_r != '0) && best_valid_r;
      default:    fwd = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    epoch_nxt       = epoch_r;
    best_valid_nxt  = best_valid_r;
    best_hops_nxt   = best_hops_r;
    parent_addr_nxt = parent_addr_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    slot_nxt        = slot_r;
    base_hop_nxt    = base_hop_r;
    base_avg_nxt    = base_avg_r;
    avg_out_nxt     = avg_out_r;
    head_tok_nxt    = '0;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end

    cmd          = '0;
    cmd.idx      = slot_r;
    cmd.addr     = req_addr_r;
    cmd.last_hop = req_hop_r;
    cmd.signal   = req_sig_r;
    cmd.quality  = req_lqi_r;
    cmd.gap_avg  = avg_out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        status_nxt  = ST_KNOWN;
        avg_out_nxt = '0;
        if (is_beacon) begin
          // A new restart epoch empties the table before the search starts.
          if (new_epoch) begin
            cmd.clr        = 1'b1;
            epoch_nxt      = req_epoch_r;
            best_valid_nxt = 1'b0;
            best_hops_nxt  = NO_HOPS;
            count_nxt      = '0;
          end
          head_tok_nxt.vld  = 1'b1;
          head_tok_nxt.addr = req_addr_r;
          state_nxt         = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (tail_tok.vld) begin
          state_nxt = S_MULT;
          if (tail_tok.found) begin
            status_nxt   = ST_KNOWN;
            slot_nxt     = tail_tok.slot;
            base_hop_nxt = tail_tok.last_hop;
            base_avg_nxt = tail_tok.gap_avg;
          end else if (!tail_tok.free) begin
            status_nxt = ST_FULL;
          end else if (req_sig_r < min_sig_r) begin
            status_nxt = ST_WEAK;
          end else begin
            status_nxt   = ST_NEW;
            slot_nxt     = tail_tok.free_slot;
            base_hop_nxt = req_hop_r;
            base_avg_nxt = AVG_UNITY;
            count_nxt    = count_r + CNT_W'(1);
            if (req_hop_r < HOP_W'(best_hops_r)) begin
              best_hops_nxt   = PHOP_W'(req_hop_r);
              parent_addr_nxt = req_addr_r;
              best_valid_nxt  = 1'b1;
            end
          end
        end
      end
      S_MULT: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (upd_entry) begin
          avg_out_nxt = (sum[17:16] != 2'b00) ? {AVG_W{1'b1}} : sum[15:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.wr = is_beacon && upd_entry;
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_sig_r    <= MIN_SIG_RESET;
      weight_r     <= WEIGHT_RESET;
      epoch_r      <= '0;
      best_valid_r <= 1'b0;
      best_hops_r  <= NO_HOPS;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      head_tok_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      best_valid_r <= best_valid_nxt;
      best_hops_r  <= best_hops_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      head_tok_r   <= head_tok_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MIN_SIGNAL:  min_sig_r <= cfg_wdata[SIG_W-1:0];
          REG_EWMA_WEIGHT: weight_r  <= cfg_wdata;
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    parent_addr_r <= parent_addr_nxt;
    status_r      <= status_nxt;
    slot_r        <= slot_nxt;
    base_hop_r    <= base_hop_nxt;
    base_avg_r    <= base_avg_nxt;
    avg_out_r     <= avg_out_nxt;
    prod_gap_r    <= 17'(gap) * 17'(w_eff);
    prod_avg_r    <= 25'(base_avg_r) * 25'(w_inv);
    if (accept) begin
      req_kind_r  <= in_kind;
      req_addr_r  <= in_sender_addr;
      req_hop_r   <= in_hop_count;
      req_epoch_r <= in_restart_epoch;
      req_sig_r   <= in_signal_strength;
      req_lqi_r   <= in_link_quality;
    end
    if (load_out) begin
      o_status_r   <= status_r;
      o_pvalid_r   <= best_valid_r;
      o_paddr_r    <= best_valid_r ? parent_addr_r : '0;
      o_phops_r    <= best_hops_r;
      o_count_r    <= count_r[4:0];
      o_avg_r      <= avg_out_r;
      o_ann_r      <= (status_r == ST_NEW) && best_valid_r;
      o_ann_hops_r <= ((status_r == ST_NEW) && best_valid_r) ?
                      (best_hops_r + PHOP_W'(1)) : '0;
      o_fwd_r      <= fwd;
    end
  end

  assign head_tok           = head_tok_r;
  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_parent_valid   = o_pvalid_r;
  assign out_parent_addr    = o_paddr_r;
  assign out_parent_hops    = o_phops_r;
  assign out_neighbor_count = o_count_r;
  assign out_average_gap    = o_avg_r;
  assign out_announce       = o_ann_r;
  assign out_announce_hops  = o_ann_hops_r;
  assign out_forward        = o_fwd_r;

endmodule
`default_nettype wire

>>> rtl/core/neighbor_table_min_hop_parent_core.sv
`default_nettype none
// Neighbor table with minimum-hop parent selection. Each entry of the table
// lives in its own cell, and the cells form a row through which a search token
// moves one cell per clock; the controller launches the token, reads the
// outcome at the far end, updates the running gap average with two registered
// multiplies and writes the chosen cell back. A beacon's result goes through
// these steps in order: launch the token, pass it through every cell, read the
// far end, form the average in the multiply and add states, and load the output
// register. Relay and local send queries skip the row and the average. One
// transaction is worked on at a time, and the next one is accepted only once
// the previous result has been loaded into the output register. A result held
// back by the receiver delays the load and therefore the next acceptance. A
// beacon with a new restart epoch clears every cell of the table together.
module neighbor_table_min_hop_parent_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [nthp_pkg::ADDR_W-1:0]       in_sender_addr,
  input  logic [nthp_pkg::HOP_W-1:0]        in_hop_count,
  input  logic [nthp_pkg::EPOCH_W-1:0]      in_restart_epoch,
  input  logic signed [nthp_pkg::SIG_W-1:0] in_signal_strength,
  input  logic [nthp_pkg::LQI_W-1:0]        in_link_quality,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_parent_valid,
  output logic [nthp_pkg::ADDR_W-1:0]       out_parent_addr,
  output logic [nthp_pkg::PHOP_W-1:0]       out_parent_hops,
  output logic [4:0]                        out_neighbor_count,
  output logic [nthp_pkg::AVG_W-1:0]        out_average_gap,
  output logic                              out_announce,
  output logic [nthp_pkg::PHOP_W-1:0]       out_announce_hops,
  output logic                              out_forward,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [nthp_pkg::WGT_W-1:0]        cfg_wdata
);
  import nthp_pkg::*;

  scan_tok_t tok [TABLE_ENTRIES+1];
  cell_cmd_t cmd;

  nthp_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_sender_addr     (in_sender_addr),
    .in_hop_count       (in_hop_count),
    .in_restart_epoch   (in_restart_epoch),
    .in_signal_strength (in_signal_strength),
    .in_link_quality    (in_link_quality),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_parent_valid   (out_parent_valid),
    .out_parent_addr    (out_parent_addr),
    .out_parent_hops    (out_parent_hops),
    .out_neighbor_count (out_neighbor_count),
    .out_average_gap    (out_average_gap),
    .out_announce       (out_announce),
    .out_announce_hops  (out_announce_hops),
    .out_forward        (out_forward),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .head_tok           (tok[0]),
    .tail_tok           (tok[TABLE_ENTRIES]),
    .cmd                (cmd)
  );

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    nthp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_W'(k)),
      .cmd     (cmd),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

endmodule
`default_nettype wire

>>> rtl/core/nthp_checker.sv
`default_nettype none
module nthp_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [1:0]                        out_status,
  input  logic                              out_parent_valid,
  input  logic [nthp_pkg::ADDR_W-1:0]       out_parent_addr,
  input  logic [nthp_pkg::PHOP_W-1:0]       out_parent_hops,
  input  logic [4:0]                        out_neighbor_count,
  input  logic [nthp_pkg::AVG_W-1:0]        out_average_gap,
  input  logic                              out_announce,
  input  logic [nthp_pkg::PHOP_W-1:0]       out_announce_hops,
  input  logic                              out_forward
);
  import nthp_pkg::*;

  // A result that waits keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_average_gap) && $stable(out_parent_addr))
    else $error("result changed while stalled");

  // Only one transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_parent_valid |-> out_parent_hops == NO_HOPS
      && out_parent_addr == '0)
    else $error("parent fields set without a parent");

  a_announce: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_announce |-> out_status == ST_NEW && out_parent_valid
      && out_announce_hops == out_parent_hops + PHOP_W'(1))
    else $error("announce inconsistent with status or parent");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward |-> out_parent_valid && out_neighbor_count != 5'd0
      && out_status == ST_KNOWN && out_average_gap == '0)
    else $error("forward without parent or neighbors");

endmodule

bind neighbor_table_min_hop_parent_core nthp_checker u_nthp_checker (.*);
`default_nettype wire
